// File: rtl/isotropic_elastic_tensor_core_defines.svh
// Assertion helpers for the checker file
`ifndef ISOTROPIC_ELASTIC_TENSOR_CORE_DEFINES_SVH
`define ISOTROPIC_ELASTIC_TENSOR_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low
`define IET_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low
`define IET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/iet_pkg.sv
package iet_pkg;

  localparam int GW        = 32;
  localparam int EntryW    = 48;
  localparam int L1W       = 46;
  localparam int L2W       = 32;
  localparam int NumRows   = 6;
  localparam int NumStages = 8;
  localparam int DivW      = 64;
  localparam int DenW      = 34;
  localparam int CntW      = $clog2(DivW);

  typedef logic [2:0] row_t;
  typedef logic signed [GW-1:0] gval_t;
  typedef gval_t [8:0] metric_t;

  localparam row_t LastRow = 3'd5;

  localparam logic [31:0] YoungReset   = 32'd65536;
  localparam logic [14:0] PoissonReset = 15'd19661;

  localparam logic signed [EntryW-1:0] EntryMax = {1'b0, {(EntryW-1){1'b1}}};
  localparam logic signed [EntryW-1:0] EntryMin = {1'b1, {(EntryW-1){1'b0}}};

  typedef enum logic [0:0] {
    CfgYoung   = 1'b0,
    CfgPoisson = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    LmPrep,
    LmDivL1,
    LmDivL2,
    LmIdle
  } lame_state_e;

  typedef struct packed {
    logic           busy;
    logic [L1W-1:0] l1;
    logic [L2W-1:0] l2;
  } lame_t;

  typedef struct packed {
    logic    valid;
    row_t    row;
    metric_t metric;
  } row_item_t;

  typedef struct packed {
    logic [NumStages-1:0] en;
  } pipe_ctrl_t;

  // first index of the pair for row or column position p
  function automatic logic [1:0] pair_a(row_t p);
    logic [1:0] r;
    unique case (p)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd1;
      3'd4:    r = 2'd2;
      3'd5:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_b(row_t p);
    logic [1:0] r;
    unique case (p)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      3'd5:             r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  // flat index of metric component (r, c)
  function automatic logic [3:0] gidx(logic [1:0] r, logic [1:0] c);
    return 4'({r, 1'b0}) + 4'(r) + 4'(c);
  endfunction

endpackage

// File: rtl/iet_in_if.sv
interface iet_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [iet_pkg::GW-1:0]    metric_00;
  logic signed [iet_pkg::GW-1:0]    metric_01;
  logic signed [iet_pkg::GW-1:0]    metric_02;
  logic signed [iet_pkg::GW-1:0]    metric_10;
  logic signed [iet_pkg::GW-1:0]    metric_11;
  logic signed [iet_pkg::GW-1:0]    metric_12;
  logic signed [iet_pkg::GW-1:0]    metric_20;
  logic signed [iet_pkg::GW-1:0]    metric_21;
  logic signed [iet_pkg::GW-1:0]    metric_22;

  modport source (
    output valid, metric_00, metric_01, metric_02, metric_10, metric_11,
           metric_12, metric_20, metric_21, metric_22,
    input  ready
  );

  modport sink (
    input  valid, metric_00, metric_01, metric_02, metric_10, metric_11,
           metric_12, metric_20, metric_21, metric_22,
    output ready
  );
endinterface

// File: rtl/iet_out_if.sv
interface iet_out_if;
  logic                              valid;
  logic                              ready;
  iet_pkg::row_t                     row_index;
  logic signed [iet_pkg::EntryW-1:0] entry_0;
  logic signed [iet_pkg::EntryW-1:0] entry_1;
  logic signed [iet_pkg::EntryW-1:0] entry_2;
  logic signed [iet_pkg::EntryW-1:0] entry_3;
  logic signed [iet_pkg::EntryW-1:0] entry_4;
  logic signed [iet_pkg::EntryW-1:0] entry_5;
  logic                              saturated;
  logic                              last_row;

  modport source (
    output valid, row_index, entry_0, entry_1, entry_2, entry_3, entry_4,
           entry_5, saturated, last_row,
    input  ready
  );

  modport sink (
    input  valid, row_index, entry_0, entry_1, entry_2, entry_3, entry_4,
           entry_5, saturated, last_row,
    output ready
  );
endinterface

// File: rtl/iet_lame.sv
module iet_lame (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_idx_i,
  input  logic [31:0]           cfg_data_i,
  output iet_pkg::lame_t        lame_o
);

  logic [31:0] young_q;
  logic [14:0] poisson_q;

  iet_pkg::lame_state_e state_q, state_d;

  logic [iet_pkg::DivW-1:0] dvd_q, quo_q, quo_d;
  logic [iet_pkg::DenW-1:0] den_q, rem_q, rem_d;
  logic [iet_pkg::CntW-1:0] cnt_q;
  logic [iet_pkg::L1W-1:0]  l1_q;
  logic [iet_pkg::L2W-1:0]  l2_q;

  logic cnt_last, load_l1, load_l2, step, done;

  logic [16:0] one_plus;
  logic [16:0] one_minus2;
  logic [33:0] den1;
  logic [46:0] en_prod;
  logic [63:0] num1;
  logic [48:0] num2;
  logic [17:0] den2;

  logic [iet_pkg::DenW:0]   rem_sh;
  logic [iet_pkg::DenW+1:0] diff;
  logic                     qbit;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      young_q   <= iet_pkg::YoungReset;
      poisson_q <= iet_pkg::PoissonReset;
    end else if (cfg_we_i) begin
      unique case (iet_pkg::cfg_reg_e'(cfg_idx_i))
        iet_pkg::CfgYoung:   young_q   <= cfg_data_i;
        iet_pkg::CfgPoisson: poisson_q <= cfg_data_i[14:0];
      endcase
    end
  end

  assign cnt_last = (cnt_q == iet_pkg::CntW'(iet_pkg::DivW - 1));

  // next state: any write restarts the computation
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iet_pkg::LmPrep:  state_d = iet_pkg::LmDivL1;
      iet_pkg::LmDivL1: if (cnt_last) state_d = iet_pkg::LmDivL2;
      iet_pkg::LmDivL2: if (cnt_last) state_d = iet_pkg::LmIdle;
      iet_pkg::LmIdle:  state_d = iet_pkg::LmIdle;
    endcase
    if (cfg_we_i) state_d = iet_pkg::LmPrep;
  end

  // state outputs
  always_comb begin
    load_l1     = (state_q == iet_pkg::LmPrep);
    step        = (state_q == iet_pkg::LmDivL1) || (state_q == iet_pkg::LmDivL2);
    load_l2     = (state_q == iet_pkg::LmDivL1) && cnt_last;
    done        = (state_q == iet_pkg::LmDivL2) && cnt_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iet_pkg::LmPrep;
    end else begin
      state_q <= state_d;
    end
  end

  // dividends and divisors, rounding half added up front
  always_comb begin
    one_plus   = 17'd65536 + 17'(poisson_q);
    one_minus2 = 17'd65536 - 17'({poisson_q, 1'b0});
    den1       = one_plus * one_minus2;
    en_prod    = young_q * poisson_q;
    num1       = 64'({en_prod, 16'b0}) + 64'(den1[33:1]);
    num2       = 49'({young_q, 16'b0}) + 49'(one_plus);
    den2       = {one_plus, 1'b0};
  end

  // one restoring step per cycle
  always_comb begin
    rem_sh = {rem_q, dvd_q[iet_pkg::DivW-1]};
    diff   = {1'b0, rem_sh} - {2'b0, den_q};
    qbit   = !diff[iet_pkg::DenW+1];
    rem_d  = qbit ? diff[iet_pkg::DenW-1:0] : rem_sh[iet_pkg::DenW-1:0];
    quo_d  = {quo_q[iet_pkg::DivW-2:0], qbit};
  end

  always_ff @(posedge clk_i) begin
    if (load_l1) begin
      dvd_q <= num1;
      den_q <= iet_pkg::DenW'(den1);
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
    end else if (load_l2) begin
      dvd_q <= iet_pkg::DivW'(num2);
      den_q <= iet_pkg::DenW'(den2);
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
      l1_q  <= quo_d[iet_pkg::L1W-1:0];
    end else if (step) begin
      dvd_q <= {dvd_q[iet_pkg::DivW-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= quo_d;
      cnt_q <= cnt_q + 1'b1;
      if (done) l2_q <= quo_d[iet_pkg::L2W-1:0];
    end
  end

  assign lame_o.busy = (state_q != iet_pkg::LmIdle) || cfg_we_i;
  assign lame_o.l1   = l1_q;
  assign lame_o.l2   = l2_q;

endmodule

// File: rtl/iet_rowseq.sv
module iet_rowseq (
  input  logic               clk_i,
  input  logic               rst_ni,
  iet_in_if.sink             item_i,
  input  logic               busy_i,
  input  logic               take_i,
  output iet_pkg::row_item_t row_o
);

  logic             act_q, act_d;
  iet_pkg::row_t    row_q, row_d;
  iet_pkg::metric_t metric_q;
  logic             take, accept;

  assign take         = act_q && take_i;
  // refill on the cycle the last row leaves
  assign item_i.ready = !busy_i && (!act_q || (row_q == iet_pkg::LastRow && take_i));
  assign accept       = item_i.valid && item_i.ready;

  always_comb begin
    act_d = act_q;
    row_d = row_q;
    priority if (accept) begin
      act_d = 1'b1;
      row_d = '0;
    end else if (take) begin
      if (row_q == iet_pkg::LastRow) begin
        act_d = 1'b0;
      end
      row_d = row_q + 1'b1;
    end else begin
      // hold
      act_d = act_q;
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      row_q <= '0;
    end else begin
      act_q <= act_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      metric_q[0] <= item_i.metric_00;
      metric_q[1] <= item_i.metric_01;
      metric_q[2] <= item_i.metric_02;
      metric_q[3] <= item_i.metric_10;
      metric_q[4] <= item_i.metric_11;
      metric_q[5] <= item_i.metric_12;
      metric_q[6] <= item_i.metric_20;
      metric_q[7] <= item_i.metric_21;
      metric_q[8] <= item_i.metric_22;
    end
  end

  assign row_o.valid  = act_q;
  assign row_o.row    = row_q;
  assign row_o.metric = metric_q;

endmodule

// File: rtl/iet_lane.sv
module iet_lane (
  input  logic                              clk_i,
  input  iet_pkg::pipe_ctrl_t               ctrl_i,
  input  iet_pkg::metric_t                  metric_i,
  input  iet_pkg::row_t                     row_i,
  input  iet_pkg::row_t                     col_i,
  input  logic [iet_pkg::L1W-1:0]           l1_i,
  input  logic [iet_pkg::L2W-1:0]           l2_i,
  output logic signed [iet_pkg::EntryW-1:0] entry_o,
  output logic                              clip_o
);

  localparam int AW = iet_pkg::L1W + 64;
  localparam int BW = iet_pkg::L2W + 64;
  localparam int VW = AW + 2;
  localparam int SW = VW - 32;
  localparam logic [VW-1:0] RoundHalf = VW'(33'h0_8000_0000);

  logic [1:0] gi, gj, gk, gl;
  logic signed [iet_pkg::GW-1:0] g_ij, g_kl, g_ik, g_jl, g_il, g_kj;

  logic signed [63:0] pa_q, pb_q, pc_q, a_q;
  logic signed [64:0] b_q;
  logic [63:0]        ma_q, mb_q;
  logic               na3_q, nb3_q, na4_q, nb4_q, na5_q, nb5_q;
  logic [54:0]        pp00_q, pp01_q, pp10_q, pp11_q;
  logic [63:0]        q0_q, q1_q;
  logic [AW-1:0]      mag_a_q;
  logic [BW-1:0]      mag_b_q;
  logic signed [AW:0] sa_q;
  logic signed [BW:0] sb_q;
  logic [VW-1:0]      vsum;
  logic signed [SW-1:0] s_q;
  logic signed [iet_pkg::EntryW-1:0] entry_q;
  logic               clip_q, ovf;

  always_comb begin
    gi   = iet_pkg::pair_a(row_i);
    gj   = iet_pkg::pair_b(row_i);
    gk   = iet_pkg::pair_a(col_i);
    gl   = iet_pkg::pair_b(col_i);
    g_ij = metric_i[iet_pkg::gidx(gi, gj)];
    g_kl = metric_i[iet_pkg::gidx(gk, gl)];
    g_ik = metric_i[iet_pkg::gidx(gi, gk)];
    g_jl = metric_i[iet_pkg::gidx(gj, gl)];
    g_il = metric_i[iet_pkg::gidx(gi, gl)];
    g_kj = metric_i[iet_pkg::gidx(gk, gj)];
  end

  assign vsum = VW'(sa_q) + VW'(sb_q) + RoundHalf;
  assign ovf  = (s_q[SW-1:iet_pkg::EntryW-1] != {(SW-iet_pkg::EntryW+1){s_q[SW-1]}});

  always_ff @(posedge clk_i) begin
    // metric products
    if (ctrl_i.en[0]) begin
      pa_q <= $signed(g_ij) * $signed(g_kl);
      pb_q <= $signed(g_ik) * $signed(g_jl);
      pc_q <= $signed(g_il) * $signed(g_kj);
    end
    if (ctrl_i.en[1]) begin
      a_q <= pa_q;
      b_q <= 65'(pb_q) + 65'(pc_q);
    end
    // split into sign and magnitude
    if (ctrl_i.en[2]) begin
      ma_q  <= a_q[63] ? 64'(-a_q) : a_q;
      mb_q  <= b_q[64] ? 64'(-b_q) : b_q[63:0];
      na3_q <= a_q[63];
      nb3_q <= b_q[64];
    end
    if (ctrl_i.en[3]) begin
      pp00_q <= l1_i[22:0] * ma_q[31:0];
      pp01_q <= l1_i[22:0] * ma_q[63:32];
      pp10_q <= l1_i[iet_pkg::L1W-1:23] * ma_q[31:0];
      pp11_q <= l1_i[iet_pkg::L1W-1:23] * ma_q[63:32];
      q0_q   <= l2_i * mb_q[31:0];
      q1_q   <= l2_i * mb_q[63:32];
      na4_q  <= na3_q;
      nb4_q  <= nb3_q;
    end
    if (ctrl_i.en[4]) begin
      mag_a_q <= AW'(pp00_q) + (AW'(pp01_q) << 32) + (AW'(pp10_q) << 23)
               + (AW'(pp11_q) << 55);
      mag_b_q <= BW'(q0_q) + (BW'(q1_q) << 32);
      na5_q   <= na4_q;
      nb5_q   <= nb4_q;
    end
    // restore signs
    if (ctrl_i.en[5]) begin
      sa_q <= na5_q ? -$signed({1'b0, mag_a_q}) : $signed({1'b0, mag_a_q});
      sb_q <= nb5_q ? -$signed({1'b0, mag_b_q}) : $signed({1'b0, mag_b_q});
    end
    // sum, round half up, drop 32 fraction bits
    if (ctrl_i.en[6]) begin
      s_q <= $signed(vsum[VW-1:32]);
    end
    // clip to the entry range
    if (ctrl_i.en[7]) begin
      entry_q <= ovf ? (s_q[SW-1] ? iet_pkg::EntryMin : iet_pkg::EntryMax)
                     : s_q[iet_pkg::EntryW-1:0];
      clip_q  <= ovf;
    end
  end

  assign entry_o = entry_q;
  assign clip_o  = clip_q;

endmodule

// File: rtl/isotropic_elastic_tensor_core.sv
// Isotropic linear elastic constitutive matrix from a 3x3 metric tensor.
// item_i takes one metric (nine signed Q8.24 components) per item; row_o
// gives six row items per metric, row_index 0 to 5, last_row on the sixth,
// each row six signed Q16.32 entries that clip to the 48-bit range and set
// saturated. Both channels move an item when valid and ready are high.
// Young's modulus (index 0) and Poisson's ratio (index 1) are to be written on
// the cfg port only while no item is in flight; the block does not enforce it.
// The row sequencer issues one row a cycle, while the pipeline does not stall,
// into the eight-stage entry pipeline (six lanes), and can take the next
// metric as the last row of the current one leaves.
// After reset and after every configuration write the Lame constants are
// recomputed by a shared radix-2 divider (a prepare state, then one division
// for l1 and one for l2); item_i is not ready meanwhile. Reset restores the
// default modulus and ratio and empties the pipeline.
// A stall on row_o holds the output register; the stages behind it keep
// filling until they are full. item_i is ready only while the row sequencer
// holds no metric or its last row moves on. Nothing is dropped or repeated.
module isotropic_elastic_tensor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  iet_in_if.sink      item_i,
  iet_out_if.source   row_o
);

  iet_pkg::lame_t      lame;
  iet_pkg::row_item_t  row_item;
  iet_pkg::pipe_ctrl_t ctrl;

  logic [iet_pkg::NumStages-1:0] v_q, v_d, en;
  iet_pkg::row_t                 rowp_q [iet_pkg::NumStages];
  iet_pkg::row_t                 rowp_d [iet_pkg::NumStages];

  logic signed [iet_pkg::EntryW-1:0] entry [iet_pkg::NumRows];
  logic [iet_pkg::NumRows-1:0]       clip;

  iet_lame u_lame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .lame_o     (lame)
  );

  iet_rowseq u_rowseq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_i),
    .busy_i (lame.busy),
    .take_i (en[0]),
    .row_o  (row_item)
  );

  // a stage advances when empty or when the one after it advances
  always_comb begin
    en[iet_pkg::NumStages-1] = !v_q[iet_pkg::NumStages-1] || row_o.ready;
    for (int s = iet_pkg::NumStages - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
    ctrl.en = en;
  end

  always_comb begin
    v_d       = {v_q[iet_pkg::NumStages-2:0], row_item.valid};
    rowp_d[0] = row_item.row;
    for (int s = 1; s < iet_pkg::NumStages; s++) begin
      rowp_d[s] = rowp_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < iet_pkg::NumStages; s++) begin
        if (en[s]) v_q[s] <= v_d[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < iet_pkg::NumStages; s++) begin
      if (en[s]) rowp_q[s] <= rowp_d[s];
    end
  end

  for (genvar c = 0; c < iet_pkg::NumRows; c++) begin : g_lane
    iet_lane u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .metric_i (row_item.metric),
      .row_i    (row_item.row),
      .col_i    (iet_pkg::row_t'(c)),
      .l1_i     (lame.l1),
      .l2_i     (lame.l2),
      .entry_o  (entry[c]),
      .clip_o   (clip[c])
    );
  end

  assign row_o.valid     = v_q[iet_pkg::NumStages-1];
  assign row_o.row_index = rowp_q[iet_pkg::NumStages-1];
  assign row_o.entry_0   = entry[0];
  assign row_o.entry_1   = entry[1];
  assign row_o.entry_2   = entry[2];
  assign row_o.entry_3   = entry[3];
  assign row_o.entry_4   = entry[4];
  assign row_o.entry_5   = entry[5];
  assign row_o.saturated = |clip;
  assign row_o.last_row  = (rowp_q[iet_pkg::NumStages-1] == iet_pkg::LastRow);

endmodule

// File: rtl/iet_checker.sv
`include "isotropic_elastic_tensor_core_defines.svh"

module iet_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input iet_pkg::row_t row_index_i,
  input logic          last_row_i
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_i;

  // six rows per metric: never two metrics on adjacent cycles
  `IET_ASSERT_NEXT(a_in_spacing, in_acc, !in_acc, "metric taken on adjacent cycles")
  `IET_ASSERT(a_row_range, out_valid_i, row_index_i <= iet_pkg::LastRow, "row index out of range")
  `IET_ASSERT(a_last_flag, out_valid_i, last_row_i == (row_index_i == iet_pkg::LastRow), "last_row mismatch")
  `IET_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "row dropped under stall")

endmodule

bind isotropic_elastic_tensor_core iet_checker u_iet_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (row_o.valid),
  .out_ready_i (row_o.ready),
  .row_index_i (row_o.row_index),
  .last_row_i  (row_o.last_row)
);

// File: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import iet_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 20;
  localparam int NumPhases     = 8;
  localparam int PhaseItems    = 54;

  // pair (hi, lo) for row or column position 0..5
  localparam logic [5:0][1:0] PairHi = {2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd0};
  localparam logic [5:0][1:0] PairLo = {2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0};

  localparam gval_t GZero = 32'sd0;
  localparam gval_t GMin  = 32'sh8000_0000;
  localparam gval_t GMax  = 32'sh7fff_ffff;
  localparam gval_t GOne  = 32'sh0100_0000;
  localparam gval_t GAltA = 32'sh5555_5555;
  localparam gval_t GAltB = 32'shaaaa_aaaa;

  localparam logic [31:0] YoungMax   = 32'hffff_ffff;
  localparam logic [14:0] PoissonMax = 15'h7fff;

  typedef enum logic [1:0] {
    ChkModel,
    ChkZero,
    ChkClipHigh
  } row_check_e;

  typedef enum logic [1:0] {
    RxOpen,
    RxLight,
    RxHeavy,
    RxPeriodic
  } rx_mode_e;

  typedef struct {
    logic [31:0] young;
    logic [14:0] poisson;
    metric_t     metric;
    row_check_e  check;
  } directed_item_t;

  typedef struct packed {
    row_t                             row;
    logic [NumRows-1:0][EntryW-1:0]   entry;
    logic                             saturated;
    logic                             last;
  } row_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  iet_in_if  item_if ();
  iet_out_if row_if ();

  isotropic_elastic_tensor_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_if),
    .row_o      (row_if)
  );

  always #6 clk_i = ~clk_i;

  // material as the block should hold it
  logic [31:0] young_q = YoungReset;
  logic [14:0] poisson_q = PoissonReset;

  row_result_t pending_rows[$];

  int metrics_sent;
  int directed_sent;
  int settings_used;
  int rows_checked;
  int rows_clipped;
  int failures;
  int idle_cycles;
  int burst_left;
  bit item_hi;

  rx_mode_e rx_mode = RxOpen;
  int       rx_left;
  int       rx_cycle;

  // Exact Lame constants and tensor entries for one metric, rounded and clipped
  function automatic void expand_stiffness(metric_t m);
    logic [63:0]         e, n, den1, den2, l1, l2;
    logic signed [127:0] lam1, lam2, prod_a, prod_b, acc, rounded;
    gval_t               g [3][3];
    row_result_t         res;
    int                  i, j, k, l;
    e    = 64'(young_q);
    n    = 64'(poisson_q);
    den1 = (64'd65536 + n) * (64'd65536 - 64'd2 * n);
    den2 = 64'd2 * (64'd65536 + n);
    l1   = (e * n * 64'd65536 + den1 / 64'd2) / den1;
    l2   = (e * 64'd65536 + den2 / 64'd2) / den2;
    lam1 = $signed({64'd0, l1});
    lam2 = $signed({64'd0, l2});
    for (int t = 0; t < 9; t++) begin
      g[t / 3][t % 3] = m[t];
    end
    for (int r = 0; r < NumRows; r++) begin
      i = int'(PairHi[r]);
      j = int'(PairLo[r]);
      res.row       = row_t'(r);
      res.saturated = 1'b0;
      res.last      = (r == NumRows - 1);
      for (int c = 0; c < NumRows; c++) begin
        k = int'(PairHi[c]);
        l = int'(PairLo[c]);
        prod_a = longint'(g[i][j]) * longint'(g[k][l]);
        prod_b = longint'(g[i][k]) * longint'(g[j][l]);
        prod_b = prod_b + longint'(g[i][l]) * longint'(g[k][j]);
        acc     = lam1 * prod_a + lam2 * prod_b;
        rounded = (acc + 128'sd2147483648) >>> 32;
        if (rounded > EntryMax) begin
          rounded       = EntryMax;
          res.saturated = 1'b1;
        end else if (rounded < EntryMin) begin
          rounded       = EntryMin;
          res.saturated = 1'b1;
        end
        res.entry[c] = rounded[EntryW-1:0];
      end
      pending_rows.push_back(res);
    end
  endfunction

  task automatic send_metric(metric_t m, row_check_e check);
    row_result_t       fixed;
    logic [EntryW-1:0] v;
    item_if.valid     <= 1'b1;
    item_if.metric_00 <= m[0];
    item_if.metric_01 <= m[1];
    item_if.metric_02 <= m[2];
    item_if.metric_10 <= m[3];
    item_if.metric_11 <= m[4];
    item_if.metric_12 <= m[5];
    item_if.metric_20 <= m[6];
    item_if.metric_21 <= m[7];
    item_if.metric_22 <= m[8];
    item_hi = 1'b1;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    metrics_sent++;
    if (check == ChkModel) begin
      expand_stiffness(m);
    end else begin
      v = (check == ChkClipHigh) ? EntryMax : '0;
      for (int r = 0; r < NumRows; r++) begin
        fixed.row       = row_t'(r);
        fixed.entry     = {NumRows{v}};
        fixed.saturated = (check == ChkClipHigh);
        fixed.last      = (r == NumRows - 1);
        pending_rows.push_back(fixed);
      end
    end
  endtask

  task automatic hold_sender();
    if (item_hi) begin
      item_if.valid <= 1'b0;
      item_hi = 1'b0;
    end
  endtask

  // Bursts of back-to-back items, broken by random gaps
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        hold_sender();
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain_rows();
    hold_sender();
    while (pending_rows.size() != 0) @(posedge clk_i);
  endtask

  // Write both registers once the pipeline is empty
  task automatic set_material(logic [31:0] young, logic [14:0] poisson);
    drain_rows();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgYoung;
    cfg_data_i <= young;
    @(posedge clk_i);
    cfg_idx_i  <= CfgPoisson;
    cfg_data_i <= {17'd0, poisson};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    young_q   = young;
    poisson_q = poisson;
    settings_used++;
  endtask

  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(40, 300);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RxOpen:  row_if.ready <= 1'b1;
      RxLight: row_if.ready <= ($urandom_range(0, 3) != 0);
      RxHeavy: row_if.ready <= ($urandom_range(0, 3) == 0);
      default: row_if.ready <= ((rx_cycle % 7) < 4);
    endcase
  end

  always @(posedge clk_i) begin
    row_result_t want, got;
    if (rst_ni && row_if.valid && row_if.ready) begin
      got.row       = row_if.row_index;
      got.entry     = {row_if.entry_5, row_if.entry_4, row_if.entry_3,
                       row_if.entry_2, row_if.entry_1, row_if.entry_0};
      got.saturated = row_if.saturated;
      got.last      = row_if.last_row;
      rows_checked++;
      if (got.saturated) rows_clipped++;
      if (pending_rows.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected row item: row=%0d sat=%0b last=%0b",
                   got.row, got.saturated, got.last);
        end
      end else begin
        want = pending_rows.pop_front();
        if (want != got) begin
          failures++;
          if (failures <= 10) begin
            $display("mismatch in row item %0d: expected row=%0d sat=%0b last=%0b,",
                     rows_checked - 1, want.row, want.saturated, want.last);
            $display("  got row=%0d sat=%0b last=%0b", got.row, got.saturated, got.last);
            $display("  expected %h %h %h %h %h %h", want.entry[0], want.entry[1],
                     want.entry[2], want.entry[3], want.entry[4], want.entry[5]);
            $display("  got      %h %h %h %h %h %h", got.entry[0], got.entry[1],
                     got.entry[2], got.entry[3], got.entry[4], got.entry[5]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (item_if.valid && item_if.ready) || (row_if.valid && row_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("timeout: no item moved for %0d cycles", WatchdogLimit);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    directed_item_t plan[$];
    metric_t        m;
    logic [31:0]    young;
    logic [14:0]    poisson;
    int             kind;
    item_if.valid     = 1'b0;
    item_if.metric_00 = '0;
    item_if.metric_01 = '0;
    item_if.metric_02 = '0;
    item_if.metric_10 = '0;
    item_if.metric_11 = '0;
    item_if.metric_12 = '0;
    item_if.metric_20 = '0;
    item_if.metric_21 = '0;
    item_if.metric_22 = '0;
    row_if.ready      = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CfgYoung;
    cfg_data_i        = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // metric packs as {g22, g21, g20, g12, g11, g10, g02, g01, g00}
    plan.push_back('{YoungReset, PoissonReset, {9{GZero}}, ChkZero});
    plan.push_back('{YoungReset, PoissonReset, {9{GMax}}, ChkModel});
    plan.push_back('{YoungReset, PoissonReset, {9{GMin}}, ChkModel});
    plan.push_back('{YoungReset, PoissonReset,
                     {GOne, GZero, GZero, GZero, GOne, GZero, GZero, GZero, GOne}, ChkModel});
    plan.push_back('{YoungReset, PoissonReset,
                     {GMax, GZero, GZero, GZero, GMin, GZero, GZero, GZero, GMax}, ChkModel});
    plan.push_back('{YoungReset, PoissonReset,
                     {GAltA, GAltB, GAltA, GAltB, GAltA, GAltB, GAltA, GAltB, GAltA}, ChkModel});
    plan.push_back('{YoungReset, PoissonReset,
                     {GAltB, GAltA, GAltB, GAltA, GAltB, GAltA, GAltB, GAltA, GAltB}, ChkModel});
    plan.push_back('{YoungReset, PoissonReset,
                     {32'sh0120_0000, -32'sh0040_0000, 32'sh0003_0000, 32'sh00c0_0000,
                      32'sh0200_0000, -32'sh0180_0000, 32'sh0010_0001, 32'sh0080_0000,
                      -32'sh00ff_ffff}, ChkModel});
    // stiffest material: a uniform nonzero metric clips every entry high
    plan.push_back('{YoungMax, PoissonMax, {9{GMin}}, ChkClipHigh});
    plan.push_back('{YoungMax, PoissonMax, {9{GMax}}, ChkClipHigh});
    plan.push_back('{YoungMax, PoissonMax, {9{GZero}}, ChkZero});
    plan.push_back('{YoungMax, PoissonMax,
                     {GMax, GZero, GZero, GZero, GMin, GZero, GZero, GZero, GMax}, ChkModel});
    plan.push_back('{YoungMax, PoissonMax,
                     {GZero, GZero, GZero, GZero, GZero, GMax, GZero, GMin, GZero}, ChkModel});
    plan.push_back('{YoungMax, PoissonMax,
                     {GOne, GZero, GZero, GZero, GOne, GZero, GZero, GZero, GOne}, ChkModel});
    // zero ratio: only the shear term remains
    plan.push_back('{YoungMax, 15'd0, {9{GMin}}, ChkClipHigh});
    plan.push_back('{YoungMax, 15'd0,
                     {GAltA, GAltB, GAltA, GAltB, GAltA, GAltB, GAltA, GAltB, GAltA}, ChkModel});
    // zero modulus: everything vanishes
    plan.push_back('{32'd0, PoissonMax, {9{GMin}}, ChkZero});
    plan.push_back('{32'd0, PoissonMax,
                     {GAltB, GAltA, GAltB, GAltA, GAltB, GAltA, GAltB, GAltA, GAltB}, ChkZero});
    plan.push_back('{32'h0002_8000, 15'h2000,
                     {GOne, GZero, GZero, GZero, GOne, GZero, GZero, GZero, GOne}, ChkModel});
    plan.push_back('{32'h0002_8000, 15'h2000,
                     {32'sh0120_0000, -32'sh0040_0000, 32'sh0003_0000, 32'sh00c0_0000,
                      32'sh0200_0000, -32'sh0180_0000, 32'sh0010_0001, 32'sh0080_0000,
                      -32'sh00ff_ffff}, ChkModel});

    foreach (plan[n]) begin
      if (plan[n].young != young_q || plan[n].poisson != poisson_q) begin
        set_material(plan[n].young, plan[n].poisson);
      end
      send_metric(plan[n].metric, plan[n].check);
      directed_sent++;
      pace_sender();
    end

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin young = YoungReset; poisson = PoissonReset; end
        1: begin young = YoungMax;   poisson = PoissonMax;   end
        2: begin young = 32'd0;      poisson = 15'd0;        end
        3: begin young = 32'd1;      poisson = PoissonMax;   end
        5: begin
          young   = $urandom_range(32'h0000_4000, 32'h0010_0000);
          poisson = 15'($urandom_range(0, 32767));
        end
        6: begin young = YoungMax;   poisson = 15'd0;        end
        default: begin
          young   = $urandom;
          poisson = 15'($urandom_range(0, 32767));
        end
      endcase
      set_material(young, poisson);
      for (int n = 0; n < PhaseItems; n++) begin
        kind = $urandom_range(0, 9);
        for (int t = 0; t < 9; t++) begin
          case (kind)
            0, 1, 2, 3, 7: m[t] = gval_t'($urandom);
            9: begin
              case ($urandom_range(0, 6))
                0: m[t] = GMin;
                1: m[t] = GMax;
                2: m[t] = GZero;
                3: m[t] = -32'sd1;
                4: m[t] = 32'sd1;
                5: m[t] = GOne;
                default: m[t] = -GOne;
              endcase
            end
            // within four units of zero, where real metrics live
            default: m[t] = gval_t'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
          endcase
        end
        if (kind == 7 || kind == 8) begin
          m[3] = m[1];
          m[6] = m[2];
          m[7] = m[5];
        end
        send_metric(m, ChkModel);
        pace_sender();
      end
    end

    drain_rows();
    repeat (DrainCycles) @(posedge clk_i);
    failures += pending_rows.size();

    $display("Stiffness run: %0d metrics (%0d from the directed table) over %0d material settings",
             metrics_sent, directed_sent, settings_used);
    $display("%0d row items checked, %0d of them clipped, %0d failures",
             rows_checked, rows_clipped, failures);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
